@@ sv/sha256_stream_hasher_top_macros.svh @@
// Assertion macros for the SHA-256 stream hasher checker.
// Used by the checker file; depends on nothing else.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define SHS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert an implication that is checked during reset as well.
`define SHS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/shs_pkg.sv @@
// Package for the SHA-256 stream hasher: types, constants and round functions.
// Used by every module of the block; depends on nothing.
package shs_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } item_t;

  // Initial hash value.
  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  // Round constant table.
  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    unique case (t)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf; 6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98; 6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

@@ sv/shs_queue.sv @@
// Small queue that decouples the item front end from the compression engine.
// Depends on shs_pkg for the item type.
module shs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  shs_pkg::item_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output shs_pkg::item_t rdata_o,
  output logic           empty_o
);
  import shs_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t            mem_q [Depth];
  logic [AddrW-1:0] wptr_q, rptr_q;
  logic [AddrW:0]   cnt_q;

  assign full_o  = (cnt_q == (AddrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Store incoming transactions.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (AddrW+1)'(push_i && !full_o) - (AddrW+1)'(pop_i && !empty_o);
    end
  end
endmodule

@@ sv/shs_engine.sv @@
// Back end: block buffer, padding sequencer, 64-round compression and digest output.
// Depends on shs_pkg for constants and round helpers.
module shs_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  shs_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [31:0]    digest_word_o,
  output logic [2:0]     word_index_o,
  output logic           last_word_o
);
  import shs_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StSched = 6'b000100,
    StRound = 6'b001000,
    StFold  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  word_t       chain_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [63:0] bitlen_q, total_q;
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        pad_q;
  logic        len_q;
  logic        fin_q;
  logic        len_phase;
  logic [7:0]  pbyte;
  logic        blk_full;
  logic        lvalid;
  logic [7:0]  lbyte;

  // Length bytes fill positions 56 to 63 of the last block, after the marker.
  assign len_phase = pad_q && (len_q || fill_q == 6'd56);

  // Padding byte: marker first, then zeros, then the big-endian bit length.
  always_comb begin
    if (!pad_q) begin
      pbyte = 8'h80;
    end else if (len_phase) begin
      pbyte = 8'(total_q >> (6'd56 - {fill_q[2:0], 3'b000}));
    end else begin
      pbyte = 8'h00;
    end
  end

  assign item_pop_o = (state_q == StIdle) && item_valid_i;
  assign lvalid = (item_pop_o && item_i.present) || (state_q == StPad);
  assign lbyte  = (state_q == StPad) ? pbyte : item_i.data;
  assign blk_full = lvalid && (fill_q == 6'd63);

  // Schedule and round arithmetic.
  word_t s0, s1, wnew, t1, t2, sg0, sg1, ch, mj;
  always_comb begin
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    sg1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + sg1 + ch + round_k(rnd_q) + w_q[0];
    sg0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = sg0 + mj;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (item_pop_o) begin
          if (blk_full) state_d = StSched;
          else if (item_i.eom) state_d = StPad;
        end
      end
      StPad:   if (blk_full) state_d = StSched;
      StSched: state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = StFold;
      StFold: begin
        if (fin_q && len_q) state_d = StOut;
        else if (fin_q) state_d = StPad;
        else state_d = StIdle;
      end
      StOut:   if (pop_i && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      pad_q    <= 1'b0;
      len_q    <= 1'b0;
      fin_q    <= 1'b0;
      bitlen_q <= '0;
      total_q  <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
    end else begin
      state_q <= state_d;
      if (lvalid) fill_q <= fill_q + 6'd1;
      // Message bytes and the end marker; latch the length and restart the count.
      if (item_pop_o) begin
        if (item_i.eom) begin
          total_q  <= item_i.present ? bitlen_q + 64'd8 : bitlen_q;
          bitlen_q <= '0;
          fin_q    <= 1'b1;
          pad_q    <= 1'b0;
          len_q    <= 1'b0;
        end else if (item_i.present) begin
          bitlen_q <= bitlen_q + 64'd8;
        end
      end
      // Padding bytes: marker, zeros, then length from position 56.
      if (state_q == StPad) begin
        pad_q <= 1'b1;
        if (pad_q && fill_q == 6'd56) len_q <= 1'b1;
      end
      if (state_q == StRound) rnd_q <= rnd_q + 6'd1;
      if (state_q == StFold) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
        if (fin_q && len_q) begin
          fin_q  <= 1'b0;
          oidx_q <= '0;
        end
      end
      if (state_q == StOut && pop_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
        end
      end
    end
  end

  // Message window and working variables.
  always_ff @(posedge clk_i) begin
    if (lvalid) begin
      w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], lbyte};
    end
    if (state_q == StSched) begin
      for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
    end
    if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign empty_o       = (state_q != StOut);
  assign digest_word_o = chain_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);
endmodule

@@ sv/sha256_stream_hasher_top.sv @@
// SHA-256 stream hasher: one message byte per input transaction, eight digest
// words out per message. The back end takes bytes back to back while idle; a
// full block is then compressed by schedule load, 64 rounds on the single round
// unit and fold, and padding adds the pad bytes plus one or two block
// compressions. A queue (four entries by default) in front lets bytes arrive while a
// block compresses. Digest words are read one per pop from the chaining registers.
module sha256_stream_hasher_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import shs_pkg::*;

  item_t in_item, q_item;
  logic  q_empty, q_pop;

  assign in_item = '{data: data_byte_i, present: byte_present_i, eom: end_of_message_i};

  shs_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(in_item), .full_o(full),
    .pop_i(q_pop), .rdata_o(q_item), .empty_o(q_empty)
  );

  shs_engine u_engine (
    .clk_i, .rst_ni,
    .item_valid_i(!q_empty), .item_i(q_item), .item_pop_o(q_pop),
    .empty_o(empty), .pop_i(pop),
    .digest_word_o, .word_index_o, .last_word_o
  );
endmodule

@@ sv/sha256_stream_hasher_checker.sv @@
// Port-level checker for the SHA-256 stream hasher, with its bind.
// Depends on the assertion macro header.
`include "sha256_stream_hasher_top_macros.svh"
module sha256_stream_hasher_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] word_index_o,
  input logic       last_word_o
);
  `SHS_ASSERT(a_last_idx, clk_i, rst_ni, (!empty |-> (last_word_o == (word_index_o == 3'd7))), "last_word mismatch")
  `SHS_ASSERT(a_idx_step, clk_i, rst_ni, (!empty && pop && !last_word_o |=> !empty && word_index_o == $past(word_index_o) + 3'd1), "word index did not advance")
  `SHS_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop |=> !empty && $stable(word_index_o)), "result dropped while stalled")
  `SHS_ASSERT_ALWAYS(a_rst, clk_i, (!rst_ni |-> empty), "results shown in reset")
endmodule

bind sha256_stream_hasher_top sha256_stream_hasher_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .word_index_o, .last_word_o
);
